FILE: hw/rtl/mfdc_pkg.sv
// Package for the mesh frame deframer with CRC check.
// Holds reset values, status codes and the bytewise CRC-16 update; no dependencies.
package mfdc_pkg;

    localparam logic [7:0]  FRAME_HEAD_RST = 8'hFE;
    localparam logic [7:0]  INNER_HEAD_RST = 8'hAA;
    localparam logic [7:0]  INNER_TAIL_RST = 8'h55;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  MIN_LENGTH     = 8'd8;

    // Configuration register indices.
    localparam logic [1:0] REG_FRAME_HEAD = 2'd0;
    localparam logic [1:0] REG_INNER_HEAD = 2'd1;
    localparam logic [1:0] REG_INNER_TAIL = 2'd2;

    // Frame verdicts.
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_FIELDS   = 3'd1;
    localparam logic [2:0] STATUS_CRC      = 3'd2;
    localparam logic [2:0] STATUS_ABORTED  = 3'd3;
    localparam logic [2:0] STATUS_TOOSHORT = 3'd4;

    // One byte of CRC-16/MODBUS, reflected, least significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        integer      k;
        c = crc_in ^ {8'h00, b};
        for (k = 0; k < 8; k = k + 1) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/mesh_frame_deframer_crc_check.sv
// Top level of the mesh frame deframer with CRC check.
// Depends on mfdc_pkg for reset values, status codes and the CRC update.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_valid / s_ready    s_data_byte
//   m_       out        m_valid / m_ready    m_payload_byte, m_payload_valid,
//                                            m_frame_done, m_frame_status
//   cfg_     in         cfg_wr_en            cfg_index, cfg_wdata
//
// One item is accepted per cycle while s_ready is high; each accepted item gives one result on the next clock.
// The frame state and a single output register carry the work: the result is
// computed from the incoming byte and the frame state in the accepting cycle.
// When the output register is full and m_ready is low, s_ready is low.
// Reset is synchronous on aresetn and clears the frame state and output valid.
module mesh_frame_deframer_crc_check
    import mfdc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic       m_payload_valid,
    output logic       m_frame_done,
    output logic [2:0] m_frame_status,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata
);

    logic [7:0]  frame_head_reg;
    logic [7:0]  inner_head_reg;
    logic [7:0]  inner_tail_reg;

    logic        in_frame_reg, in_frame_next;
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic        fields_ok_reg, fields_ok_next;
    logic        crc_ok_reg, crc_ok_next;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_pvalid_reg, out_pvalid_next;
    logic        out_done_reg, out_done_next;
    logic [2:0]  out_status_reg, out_status_next;

    logic        accept;
    logic [8:0]  pos_inc;
    logic [8:0]  len_ext;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign pos_inc = pos_reg + 9'd1;
    assign len_ext = {1'b0, len_reg};

    always_comb begin
        in_frame_next   = in_frame_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        crc_next        = crc_reg;
        fields_ok_next  = fields_ok_reg;
        crc_ok_next     = crc_ok_reg;
        out_pvalid_next = 1'b0;
        out_done_next   = 1'b0;
        out_status_next = STATUS_OK;
        if (s_data_byte == frame_head_reg) begin
            if (in_frame_reg) begin
                out_done_next   = 1'b1;
                out_status_next = STATUS_ABORTED;
            end
            in_frame_next  = 1'b1;
            pos_next       = '0;
            len_next       = '0;
            crc_next       = CRC_INIT;
            fields_ok_next = 1'b1;
            crc_ok_next    = 1'b1;
        end else if (in_frame_reg) begin
            pos_next = pos_inc;
            if (pos_inc == 9'd2) begin
                len_next = s_data_byte;
                if (s_data_byte < MIN_LENGTH) begin
                    out_done_next   = 1'b1;
                    out_status_next = STATUS_TOOSHORT;
                    in_frame_next   = 1'b0;
                end
            end else if (pos_inc > 9'd2) begin
                if (pos_inc >= 9'd4 && pos_inc <= len_ext + 9'd2) begin
                    out_pvalid_next = 1'b1;
                end
                if (pos_inc >= 9'd6 && pos_inc <= len_ext - 9'd1) begin
                    crc_next = crc_byte(crc_reg, s_data_byte);
                end
                if (pos_inc == 9'd6 && s_data_byte != inner_head_reg) begin
                    fields_ok_next = 1'b0;
                end
                if (pos_inc == 9'd7 && s_data_byte != len_reg - 8'd1) begin
                    fields_ok_next = 1'b0;
                end
                if (pos_inc == len_ext && s_data_byte != crc_reg[7:0]) begin
                    crc_ok_next = 1'b0;
                end
                if (pos_inc == len_ext + 9'd1 && s_data_byte != crc_reg[15:8]) begin
                    crc_ok_next = 1'b0;
                end
                if (pos_inc == len_ext + 9'd2 && s_data_byte != inner_tail_reg) begin
                    fields_ok_next = 1'b0;
                end
                if (pos_inc == len_ext + 9'd3) begin
                    out_done_next = 1'b1;
                    in_frame_next = 1'b0;
                    if (!fields_ok_reg) begin
                        out_status_next = STATUS_FIELDS;
                    end else if (!crc_ok_reg) begin
                        out_status_next = STATUS_CRC;
                    end else begin
                        out_status_next = STATUS_OK;
                    end
                end
            end
        end
        out_byte_next = out_pvalid_next ? s_data_byte : 8'h00;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_head_reg <= FRAME_HEAD_RST;
            inner_head_reg <= INNER_HEAD_RST;
            inner_tail_reg <= INNER_TAIL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_HEAD: frame_head_reg <= cfg_wdata;
                REG_INNER_HEAD: inner_head_reg <= cfg_wdata;
                REG_INNER_TAIL: inner_tail_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg  <= 1'b0;
            pos_reg       <= '0;
            len_reg       <= '0;
            crc_reg       <= CRC_INIT;
            fields_ok_reg <= 1'b1;
            crc_ok_reg    <= 1'b1;
        end else if (accept) begin
            in_frame_reg  <= in_frame_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            crc_reg       <= crc_next;
            fields_ok_reg <= fields_ok_next;
            crc_ok_reg    <= crc_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_byte_reg   <= out_byte_next;
            out_pvalid_reg <= out_pvalid_next;
            out_done_reg   <= out_done_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_payload_byte  = out_byte_reg;
    assign m_payload_valid = out_pvalid_reg;
    assign m_frame_done    = out_done_reg;
    assign m_frame_status  = out_status_reg;

    // A byte is never both payload and the end of a frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_payload_valid && m_frame_done))
        else $error("payload and frame end reported on the same item");

    // A verdict other than ok only comes with the end of a frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_done) |-> (m_frame_status == STATUS_OK))
        else $error("status reported without frame end");

    // A head byte always opens a fresh frame at position zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data_byte == frame_head_reg) |=>
            (in_frame_reg && pos_reg == 9'd0 && crc_reg == CRC_INIT))
        else $error("head byte did not restart the frame");

endmodule
